// ===== hdl/acfpe_pkg.sv =====
// ----------------------------------------------------------------------------
// acfpe_pkg
// Shared constants and types for the autocorrelation pitch period estimator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package acfpe_pkg;

  // Frame and value geometry
  localparam int MAX_LAGS = 512;
  localparam int VALUE_W  = 24;
  localparam int LAG_W    = $clog2(MAX_LAGS + 1);

  // Register widths
  localparam int SR_W     = 16;
  localparam int PER_W    = 10;
  localparam int CMP_W    = (LAG_W > PER_W) ? LAG_W : PER_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SR_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_MIN_PERIOD  = 2'd1,
    CFG_MAX_PERIOD  = 2'd2
  } cfg_reg_e;

  // Divider
  localparam int CNT_W = $clog2(SR_W);

  // One finished frame handed from front to back
  typedef struct packed {
    logic [PER_W-1:0] period;
    logic [SR_W-1:0]  sample_rate;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

// ===== hdl/acfpe_if.sv =====
// ----------------------------------------------------------------------------
// acfpe_if
// Valid/ready channels for ACF input beats and pitch result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface acfpe_in_if import acfpe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] acf_value;
  logic                      last_lag;

  modport source (output valid, output acf_value, output last_lag, input ready);
  modport sink   (input valid, input acf_value, input last_lag, output ready);
endinterface

interface acfpe_out_if import acfpe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PER_W-1:0] pitch_period;
  logic [SR_W-1:0]  pitch_hz;

  modport source (output valid, output pitch_period, output pitch_hz, input ready);
  modport sink   (input valid, input pitch_period, input pitch_hz, output ready);
endinterface

`default_nettype wire

// ===== hdl/acfpe_front.sv =====
// ----------------------------------------------------------------------------
// acfpe_front
// Per-lag minimum/maximum search; pushes the frame's period on its last beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfpe_front import acfpe_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [VALUE_W-1:0] acf_value,
  input  wire logic                      last_lag,
  input  wire logic [SR_W-1:0]           sample_rate,
  input  wire logic [PER_W-1:0]          min_period,
  input  wire logic [PER_W-1:0]          max_period,
  input  wire q_stat_t                   q_stat,
  output logic                           push,
  output job_t                           push_job
);

  logic [LAG_W-1:0]          lag_counter;
  logic signed [VALUE_W-1:0] running_min;
  logic signed [VALUE_W-1:0] running_max;
  logic [PER_W-1:0]          max_lag;
  logic                      window_seen;

  logic signed [VALUE_W-1:0] running_min_next;
  logic signed [VALUE_W-1:0] running_max_next;
  logic [PER_W-1:0]          max_lag_next;
  logic                      window_seen_next;
  logic                      in_window;
  logic                      accept;
  logic [PER_W-1:0]          period;

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign in_window = (lag_counter < LAG_W'(MAX_LAGS))
                  && (CMP_W'(lag_counter) >= CMP_W'(min_period))
                  && (CMP_W'(lag_counter) <  CMP_W'(max_period));

  always_comb begin
    running_min_next = running_min;
    running_max_next = running_max;
    max_lag_next     = max_lag;
    window_seen_next = window_seen;
    if (in_window) begin
      if (!window_seen || (acf_value < running_min)) begin
        running_min_next = acf_value;
        running_max_next = acf_value;
        max_lag_next     = PER_W'(lag_counter);
        window_seen_next = 1'b1;
      end else if (acf_value > running_max) begin
        running_max_next = acf_value;
        max_lag_next     = PER_W'(lag_counter);
      end
    end
  end

  // Clamp the found lag to the period limits
  always_comb begin
    priority if (!window_seen_next) begin
      period = max_period;
    end else if (max_lag_next > max_period) begin
      period = max_period;
    end else if (max_lag_next < min_period) begin
      period = min_period;
    end else begin
      period = max_lag_next;
    end
  end

  assign push                 = accept && last_lag;
  assign push_job.period      = period;
  assign push_job.sample_rate = sample_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      lag_counter <= '0;
      running_min <= '0;
      running_max <= '0;
      max_lag     <= '0;
      window_seen <= 1'b0;
    end else if (accept) begin
      if (last_lag) begin
        lag_counter <= '0;
        running_min <= '0;
        running_max <= '0;
        max_lag     <= '0;
        window_seen <= 1'b0;
      end else begin
        if (lag_counter < LAG_W'(MAX_LAGS)) begin
          lag_counter <= lag_counter + 1'b1;
        end
        running_min <= running_min_next;
        running_max <= running_max_next;
        max_lag     <= max_lag_next;
        window_seen <= window_seen_next;
      end
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    push |=> (lag_counter == '0) && !window_seen)
    else $error("frame state not cleared after last beat");

  a_max_after_min: assert property (@(posedge clk) disable iff (rst)
    window_seen |-> (running_max >= running_min))
    else $error("running max below running min");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

`default_nettype wire

// ===== hdl/acfpe_queue.sv =====
// ----------------------------------------------------------------------------
// acfpe_queue
// Two-entry job queue between the search front and the divider back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfpe_queue import acfpe_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      pop_job,
  output q_stat_t   q_stat
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign q_stat.empty = (count == 2'd0);
  assign q_stat.full  = (count == 2'd2);
  assign pop_job      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd0 || count == 2'd2) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== hdl/acfpe_back.sv =====
// ----------------------------------------------------------------------------
// acfpe_back
// Radix-2 restoring divider for sample_rate / period and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acfpe_back import acfpe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire q_stat_t  q_stat,
  input  wire job_t     pop_job,
  output logic          pop,
  acfpe_out_if.source   out_ch
);

  bk_state_t        state;
  bk_state_t        state_next;
  logic [PER_W-1:0] divisor;
  logic [PER_W:0]   rem;
  logic [SR_W-1:0]  quo;
  logic [CNT_W-1:0] cnt;
  logic [SR_W-1:0]  dividend;
  logic [PER_W:0]   rem_sh;
  logic             q_bit;

  assign rem_sh = {rem[PER_W-1:0], quo[SR_W-1]};
  assign q_bit  = (rem_sh >= {1'b0, divisor});

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          state_next = (pop_job.period == '0) ? BK_DONE : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt == '0) state_next = BK_DONE;
      end
      BK_DONE: begin
        if (out_ch.ready) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    pop                 = (state == BK_IDLE) && !q_stat.empty;
    out_ch.valid        = (state == BK_DONE);
    out_ch.pitch_period = divisor;
    out_ch.pitch_hz     = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Quotient bits shift in where dividend bits shift out
  always_ff @(posedge clk) begin
    if (pop) begin
      divisor  <= pop_job.period;
      dividend <= pop_job.sample_rate;
      rem      <= '0;
      cnt      <= CNT_W'(SR_W - 1);
      quo      <= (pop_job.period == '0) ? '1 : pop_job.sample_rate;
    end else if (state == BK_DIV) begin
      rem <= q_bit ? (rem_sh - {1'b0, divisor}) : rem_sh;
      quo <= {quo[SR_W-2:0], q_bit};
      cnt <= cnt - 1'b1;
    end
  end

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DIV) |-> (divisor != '0))
    else $error("divide by zero period");

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != BK_IDLE))
    else $error("job popped but divider idle");

  a_quotient_ok: assert property (@(posedge clk) disable iff (rst)
    (state == BK_DONE) && (divisor != '0) |->
      ((SR_W + PER_W)'(quo) * (SR_W + PER_W)'(divisor) <= (SR_W + PER_W)'(dividend))
      && ((SR_W + PER_W)'(dividend) - (SR_W + PER_W)'(quo) * (SR_W + PER_W)'(divisor)
          < (SR_W + PER_W)'(divisor)))
    else $error("quotient inconsistent");

endmodule

`default_nettype wire

// ===== hdl/acf_pitch_period_estimator.sv =====
// ----------------------------------------------------------------------------
// acf_pitch_period_estimator
// Autocorrelation pitch detector: period and frequency per frame.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one autocorrelation beat per lag, lag 0 first. last_lag
//   marks the final beat of a frame. Each frame yields one beat on out_ch
//   with pitch_period (lag of the highest value after the deepest dip inside
//   [min_period, max_period), clamped) and pitch_hz = sample_rate/period,
//   or 65535 if the period is zero.
//   Throughput: one input beat per cycle. The front search takes the beat
//   in the cycle it is offered and hands finished frames to a two-entry
//   queue; in_ch.ready drops only while that queue is full.
//   Divider: the back pops a queued frame whenever it is idle and runs a
//   one-bit-per-cycle restoring divider on it (skipped for a zero period),
//   which sets the frame rate limit.
//   Stall: a result holds on out_ch until ready; meanwhile up to two more
//   frames queue up, after which in_ch stalls.
//   Reset (rst, synchronous): registers go to 8000 / 16 / 160, frame state
//   and queue clear. Write configuration only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module acf_pitch_period_estimator import acfpe_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  acfpe_in_if.sink                   in_ch,
  acfpe_out_if.source                out_ch
);

  // Configuration registers
  logic [SR_W-1:0]  sample_rate;
  logic [PER_W-1:0] min_period;
  logic [PER_W-1:0] max_period;

  // Front to queue to back
  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    pop_job;
  q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate <= SR_W'(8000);
      min_period  <= PER_W'(16);
      max_period  <= PER_W'(160);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_RATE: sample_rate <= cfg_data[SR_W-1:0];
        CFG_MIN_PERIOD:  min_period  <= cfg_data[PER_W-1:0];
        CFG_MAX_PERIOD:  max_period  <= cfg_data[PER_W-1:0];
        default:         ; // unmapped index: ignored
      endcase
    end
  end

  acfpe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .acf_value   (in_ch.acf_value),
    .last_lag    (in_ch.last_lag),
    .sample_rate (sample_rate),
    .min_period  (min_period),
    .max_period  (max_period),
    .q_stat      (q_stat),
    .push        (push),
    .push_job    (push_job)
  );

  acfpe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .q_stat   (q_stat)
  );

  acfpe_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_stat  (q_stat),
    .pop_job (pop_job),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== tb/sv/acfpe_checker.sv =====
// ----------------------------------------------------------------------------
// acfpe_checker
// Watches the ACF and pitch channels, predicts each frame's pitch and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acfpe_checker import acfpe_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  acfpe_in_if                   in_mon,
  acfpe_out_if                  out_mon,
  output int                    fail_count,
  output int                    pending,
  output int                    frames_checked
);

  typedef struct {
    logic [PER_W-1:0] period;
    logic [SR_W-1:0]  hz;
  } pitch_t;

  // shadow registers
  logic [SR_W-1:0]  rate;
  logic [PER_W-1:0] lo_per;
  logic [PER_W-1:0] hi_per;

  // frame search state
  int unsigned               lag_pos;
  logic signed [VALUE_W-1:0] dip;
  logic signed [VALUE_W-1:0] peak;
  int unsigned               peak_lag;
  bit                        window_seen;

  pitch_t pending_pitch[$];

  function void clear_search();
    lag_pos     = 0;
    dip         = '0;
    peak        = '0;
    peak_lag    = 0;
    window_seen = 1'b0;
  endfunction

  // one ACF beat: update dip/peak search, close the frame on the last beat
  function void search_lag(input logic signed [VALUE_W-1:0] v, input logic last);
    pitch_t est;
    if (lag_pos < MAX_LAGS && lag_pos >= lo_per && lag_pos < hi_per) begin
      if (!window_seen || v < dip) begin
        dip         = v;
        peak        = v;
        peak_lag    = lag_pos;
        window_seen = 1'b1;
      end else if (v > peak) begin
        peak     = v;
        peak_lag = lag_pos;
      end
    end
    if (lag_pos < MAX_LAGS)
      lag_pos++;
    if (last) begin
      if (!window_seen || peak_lag > hi_per)
        est.period = hi_per;
      else if (peak_lag < lo_per)
        est.period = lo_per;
      else
        est.period = PER_W'(peak_lag);
      if (est.period == '0)
        est.hz = '1;
      else
        est.hz = SR_W'(rate / est.period);
      pending_pitch.push_back(est);
      clear_search();
    end
  endfunction

  function void check_pitch(input logic [PER_W-1:0] period, input logic [SR_W-1:0] hz);
    pitch_t est;
    if (pending_pitch.size() == 0) begin
      $display("%0t: unexpected pitch beat, period %0d hz %0d", $time, period, hz);
      fail_count++;
    end else begin
      est = pending_pitch.pop_front();
      frames_checked++;
      if (period !== est.period) begin
        $display("%0t: pitch_period expected %0d, got %0d", $time, est.period, period);
        fail_count++;
      end
      if (hz !== est.hz) begin
        $display("%0t: pitch_hz expected %0d, got %0d", $time, est.hz, hz);
        fail_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rate           = 16'd8000;
      lo_per         = 10'd16;
      hi_per         = 10'd160;
      fail_count     = 0;
      frames_checked = 0;
      clear_search();
      pending_pitch.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_e'(cfg_index))
          CFG_SAMPLE_RATE: rate   = cfg_data[SR_W-1:0];
          CFG_MIN_PERIOD:  lo_per = cfg_data[PER_W-1:0];
          CFG_MAX_PERIOD:  hi_per = cfg_data[PER_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        search_lag(in_mon.acf_value, in_mon.last_lag);
      if (out_mon.valid && out_mon.ready)
        check_pitch(out_mon.pitch_period, out_mon.pitch_hz);
    end
    pending = pending_pitch.size();
  end

endmodule

// ===== tb/sv/tb_acf_pitch_period_estimator.sv =====
// ----------------------------------------------------------------------------
// tb_acf_pitch_period_estimator
// Drives ACF frames and register settings into the pitch estimator; a
// side checker predicts each frame's period and Hz and compares them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_acf_pitch_period_estimator;
  import acfpe_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int frames_checked;

  // per-phase switches: when set, that side never inserts idle cycles
  bit in_steady;
  bit out_steady;

  int beats_sent;
  int phases_run;
  int walk_acc;   // random-walk state for smooth ACF shapes

  acfpe_in_if  in_ch();
  acfpe_out_if out_ch();

  acf_pitch_period_estimator DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  acfpe_checker u_pitch_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .fail_count     (fail_count),
    .pending        (pending),
    .frames_checked (frames_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop. The slowest legal run is far below this (at most about 1.8k
  // beats, each after a random idle gap, plus divider and sink stalls per frame).
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  // Result sink: before each beat it holds ready low for a random gap,
  // then keeps ready high until a beat is taken.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = out_steady ? 0 : $urandom_range(0, 10);
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // One ACF beat. valid is assigned once per falling edge: it stays high
  // straight into the next beat when no gap is drawn.
  task automatic send_beat(input logic signed [VALUE_W-1:0] v, input logic last);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 10);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid     <= 1'b1;
    in_ch.acf_value <= v;
    in_ch.last_lag  <= last;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // A frame of len beats, lag 0 first. Styles: full-range noise, a random
  // walk (smooth dips and peaks, with the odd jump), or a few small values
  // so that ties are common.
  task automatic send_frame(input int len, input int style);
    logic signed [VALUE_W-1:0] v;
    int tiny;
    walk_acc = $urandom();
    for (int k = 0; k < len; k++) begin
      case (style)
        0: v = VALUE_W'($urandom());
        1: begin
          if ($urandom_range(0, 15) == 0)
            walk_acc = $urandom();
          else
            walk_acc = walk_acc + (int'($urandom_range(0, 4000)) - 2000);
          v = VALUE_W'(walk_acc);
        end
        default: begin
          tiny = int'($urandom_range(0, 4)) - 2;
          v = VALUE_W'(tiny);
        end
      endcase
      send_beat(v, k == len - 1);
    end
  endtask

  // All three registers, back to back, only while the block is idle.
  task automatic write_config(input logic [SR_W-1:0] rate, input logic [PER_W-1:0] lo,
                              input logic [PER_W-1:0] hi);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_RATE;
    cfg_data  <= rate;
    @(negedge clk);
    cfg_index <= CFG_MIN_PERIOD;
    cfg_data  <= CFG_DATA_W'(lo);
    @(negedge clk);
    cfg_index <= CFG_MAX_PERIOD;
    cfg_data  <= CFG_DATA_W'(hi);
    @(negedge clk);
    cfg_we    <= 1'b0;
    phases_run++;
  endtask

  // Drain: stop offering beats, wait until every predicted pitch has been
  // seen, then give the divider some slack.
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (24) @(negedge clk);
  endtask

  initial begin
    int  lo_i;
    int  hi_i;
    int  rate_i;
    int  len;
    int  phase_beats;
    int  budget;
    bit  long_run;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.acf_value = '0;
    in_ch.last_lag  = 1'b0;
    in_steady       = 1'b0;
    out_steady      = 1'b0;
    beats_sent      = 0;
    phases_run      = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---------------- directed frames ----------------
    // Narrow window [2, 8), top sample rate.
    write_config(16'd65535, 10'd2, 10'd8);

    // Empty window: the frame ends at lag 0, before the window opens.
    send_beat(24'sh123456, 1'b1);

    // Ties keep the first occurrence; a late new minimum at lag 7
    // restarts the peak search there, so the period is 7. Lags 0, 1
    // and 8 are outside the window and must not count.
    send_beat(24'sh7FFFFF, 1'b0);
    send_beat(24'sh000000, 1'b0);
    send_beat(24'sh000005, 1'b0);
    send_beat(24'sh000005, 1'b0);
    send_beat(24'sh000003, 1'b0);
    send_beat(24'sh000009, 1'b0);
    send_beat(24'sh000009, 1'b0);
    send_beat(-24'sh800000, 1'b0);
    send_beat(24'sh7FFFFF, 1'b1);

    // Value extremes: the first window beat is both min and max, then the
    // most negative value takes the min and the most positive the peak.
    send_beat(-24'sh800000, 1'b0);
    send_beat(24'sh7FFFFF, 1'b0);
    send_beat(24'sh7FFFFF, 1'b0);
    send_beat(-24'sh800000, 1'b0);
    send_beat(24'sh7FFFFF, 1'b0);
    send_beat(24'sh000000, 1'b1);
    drain();

    // Zero period: max_period of zero leaves the window empty and the
    // Hz output saturates. Smallest sample rate as well.
    write_config(16'd1, 10'd1, 10'd0);
    send_beat(24'sh000001, 1'b1);
    send_beat(24'sh400000, 1'b0);
    send_beat(-24'sh000001, 1'b1);
    drain();

    // min_period equal to max_period: no lag qualifies.
    write_config(16'd8000, 10'd5, 10'd5);
    for (int k = 0; k < 7; k++)
      send_beat(VALUE_W'($urandom()), k == 6);
    drain();

    // ---------------- random phases ----------------
    for (int ph = 0; ph < 14; ph++) begin
      long_run = (ph == 4);
      case ($urandom_range(0, 3))
        0:       rate_i = 1;
        1:       rate_i = 65535;
        default: rate_i = $urandom_range(1, 65535);
      endcase
      if (long_run) begin
        // Overlong frames: lags from 512 on must be ignored by the search.
        lo_i = $urandom_range(400, 511);
        hi_i = 512;
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            lo_i = 1;
            hi_i = $urandom_range(2, 40);
          end
          1: begin  // inverted or degenerate window
            lo_i = $urandom_range(1, 30);
            hi_i = $urandom_range(1, lo_i);
          end
          2: begin
            lo_i = 512;
            hi_i = 512;
          end
          3: begin
            lo_i = $urandom_range(1, 8);
            hi_i = lo_i + $urandom_range(1, 3);
          end
          default: begin
            lo_i = $urandom_range(1, 16);
            hi_i = lo_i + $urandom_range(1, 24);
          end
        endcase
      end
      write_config(SR_W'(rate_i), PER_W'(lo_i), PER_W'(hi_i));

      in_steady   = ($urandom_range(0, 3) == 0);
      out_steady  = ($urandom_range(0, 3) == 0);
      budget      = long_run ? 500 : 45;
      phase_beats = 0;
      while (phase_beats < budget) begin
        if (long_run)
          len = $urandom_range(513, 560);
        else if ($urandom_range(0, 4) == 0)
          len = $urandom_range(1, 3);
        else
          len = $urandom_range(1, (hi_i > 48 ? 48 : hi_i) + 3);
        send_frame(len, $urandom_range(0, 2));
        phase_beats += len;
      end
      drain();
    end

    in_steady  = 1'b0;
    out_steady = 1'b0;

    $display("Covered %0d ACF beats, %0d pitch beats checked, %0d register settings",
             beats_sent, frames_checked, phases_run);
    $display("incl. empty/inverted windows, zero period, ties and overlong frames");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
